/* sv/dcpc_pkg.sv */
// ---------------------------------------------------------------------------
// dcpc_pkg
// Shared widths, reset values, register codes and control bundles for the
// depth-to-color point cloud unit.
// ---------------------------------------------------------------------------
package dcpc_pkg;

   // payload widths
   localparam int DEPTH_W    = 32;
   localparam int COLOR_W    = 8;
   localparam int POINT_W    = 48;
   localparam int Q_FRAC     = 16;
   localparam int CFG_W      = 32;
   localparam int SIZE_W     = 13;
   localparam int PROD_W     = 64;
   localparam int QUO_W      = 48;
   localparam int QCNT_W     = $clog2(QUO_W + 1);

   // register port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // register reset values
   localparam logic [CFG_W-1:0]  FOCAL_X_RST  = 32'd31535923;
   localparam logic [CFG_W-1:0]  FOCAL_Y_RST  = 32'd31457280;
   localparam logic [CFG_W-1:0]  CENTER_X_RST = 32'd20938752;
   localparam logic [CFG_W-1:0]  CENTER_Y_RST = 32'd15695872;
   localparam logic [SIZE_W-1:0] WIDTH_RST    = 13'd640;
   localparam logic [SIZE_W-1:0] HEIGHT_RST   = 13'd480;

   // saturation bounds of a signed 48-bit coordinate (as magnitudes)
   localparam logic [POINT_W-1:0] POS_LIMIT = 48'h7FFF_FFFF_FFFF;
   localparam logic [POINT_W-1:0] NEG_LIMIT = 48'h8000_0000_0000;

   // register index (byte address / 4)
   typedef enum logic [2:0] {
      REG_FOCAL_X,
      REG_FOCAL_Y,
      REG_CENTER_X,
      REG_CENTER_Y,
      REG_IMAGE_WIDTH,
      REG_IMAGE_HEIGHT
   } reg_idx_type;

   typedef struct packed {
      logic [CFG_W-1:0]  focal_x;
      logic [CFG_W-1:0]  focal_y;
      logic [CFG_W-1:0]  center_x;
      logic [CFG_W-1:0]  center_y;
      logic [SIZE_W-1:0] image_width;
      logic [SIZE_W-1:0] image_height;
   } cfg_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;    // input beat taken this cycle
      logic mul;       // form both products
      logic start;     // launch both dividers
      logic load_out;  // move finished point into output register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic missing;   // incoming pixel has zero depth
      logic busy;      // a divider is still iterating
      logic out_free;  // output register can take a point this cycle
   } status_type;

endpackage

/* sv/dcpc_if.sv */
// ---------------------------------------------------------------------------
// dcpc_req_if / dcpc_rsp_if
// Valid/ready stream channels for pixels in and points out.
// ---------------------------------------------------------------------------
interface dcpc_req_if import dcpc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [DEPTH_W-1:0] depth_value;
   logic [COLOR_W-1:0] blue_in;
   logic [COLOR_W-1:0] green_in;
   logic [COLOR_W-1:0] red_in;

   modport source (output valid, depth_value, blue_in, green_in, red_in, input ready);
   modport sink   (input valid, depth_value, blue_in, green_in, red_in, output ready);
endinterface

interface dcpc_rsp_if import dcpc_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [POINT_W-1:0] point_x;
   logic signed [POINT_W-1:0] point_y;
   logic        [DEPTH_W-1:0] point_z;
   logic        [COLOR_W-1:0] blue_out;
   logic        [COLOR_W-1:0] green_out;
   logic        [COLOR_W-1:0] red_out;

   modport source (output valid, point_x, point_y, point_z, blue_out, green_out, red_out,
                   input ready);
   modport sink   (input valid, point_x, point_y, point_z, blue_out, green_out, red_out,
                   output ready);
endinterface

/* sv/dcpc_csr.sv */
// ---------------------------------------------------------------------------
// dcpc_csr
// APB-style register file holding camera intrinsics and image geometry.
// ---------------------------------------------------------------------------
module dcpc_csr import dcpc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   reg_idx_type idx;
   logic        wr_en;

   assign idx    = reg_idx_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   // write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_FOCAL_X:      cfg_in.focal_x      = pwdata;
            REG_FOCAL_Y:      cfg_in.focal_y      = pwdata;
            REG_CENTER_X:     cfg_in.center_x     = pwdata;
            REG_CENTER_Y:     cfg_in.center_y     = pwdata;
            REG_IMAGE_WIDTH:  cfg_in.image_width  = pwdata[SIZE_W-1:0];
            REG_IMAGE_HEIGHT: cfg_in.image_height = pwdata[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.focal_x      <= FOCAL_X_RST;
         cfg_ff.focal_y      <= FOCAL_Y_RST;
         cfg_ff.center_x     <= CENTER_X_RST;
         cfg_ff.center_y     <= CENTER_Y_RST;
         cfg_ff.image_width  <= WIDTH_RST;
         cfg_ff.image_height <= HEIGHT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      unique case (idx)
         REG_FOCAL_X:      prdata = cfg_ff.focal_x;
         REG_FOCAL_Y:      prdata = cfg_ff.focal_y;
         REG_CENTER_X:     prdata = cfg_ff.center_x;
         REG_CENTER_Y:     prdata = cfg_ff.center_y;
         REG_IMAGE_WIDTH:  prdata = {{(CSR_DATA_W-SIZE_W){1'b0}}, cfg_ff.image_width};
         REG_IMAGE_HEIGHT: prdata = {{(CSR_DATA_W-SIZE_W){1'b0}}, cfg_ff.image_height};
         default:          prdata = '0;
      endcase
   end

endmodule

/* sv/dcpc_div.sv */
// ---------------------------------------------------------------------------
// dcpc_div
// Radix-2 restoring divider: 64-bit dividend by 32-bit divisor, 48-bit
// quotient, one quotient bit per cycle. Overflow past 48 bits is flagged
// up front and skips the iterations.
// ---------------------------------------------------------------------------
module dcpc_div import dcpc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [PROD_W-1:0] dividend,
   input  logic [CFG_W-1:0]  divisor,
   output logic              busy,
   output logic              ovf,
   output logic [QUO_W-1:0]  quotient
);

   logic              busy_ff, busy_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic [CFG_W-1:0]  rem_ff, rem_in;
   logic [QUO_W-1:0]  low_ff, low_in;
   logic [CFG_W-1:0]  dsr_ff, dsr_in;
   logic              ovf_ff, ovf_in;

   logic [CFG_W:0]    trial;
   logic [CFG_W:0]    diff;
   logic              ge;
   logic [CFG_W-1:0]  hi;
   logic              is_zero;
   logic              hi_ge;

   // one restoring step: low_ff shifts dividend bits out and quotient bits in
   assign trial   = {rem_ff, low_ff[QUO_W-1]};
   assign ge      = trial >= {1'b0, dsr_ff};
   assign diff    = trial - {1'b0, dsr_ff};
   assign hi      = CFG_W'(dividend[PROD_W-1:QUO_W]);
   assign is_zero = dividend == '0;
   assign hi_ge   = hi >= divisor;   // quotient would need more than 48 bits

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      dsr_in  = dsr_ff;
      ovf_in  = ovf_ff;
      if (start) begin
         dsr_in  = divisor;
         rem_in  = hi;
         low_in  = dividend[QUO_W-1:0];
         ovf_in  = !is_zero && hi_ge;
         busy_in = !is_zero && !hi_ge;
         cnt_in  = QCNT_W'(QUO_W);
      end else if (busy_ff) begin
         rem_in  = ge ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
         low_in  = {low_ff[QUO_W-2:0], ge};
         cnt_in  = cnt_ff - QCNT_W'(1);
         busy_in = cnt_ff != QCNT_W'(1);
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   // data
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      low_ff <= low_in;
      dsr_ff <= dsr_in;
      ovf_ff <= ovf_in;
   end

   assign busy     = busy_ff;
   assign ovf      = ovf_ff;
   assign quotient = low_ff;

endmodule

/* sv/dcpc_ctrl.sv */
// ---------------------------------------------------------------------------
// dcpc_ctrl
// Sequencer for one pixel: take beat, multiply, divide, hand off result.
// ---------------------------------------------------------------------------
module dcpc_ctrl import dcpc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_START,
      S_WAIT,
      S_OUT
   } state_type;

   state_type state_ff;
   logic      ready_ff;

   assign req_ready    = ready_ff;
   assign cmd.accept   = req_valid && ready_ff;
   assign cmd.mul      = state_ff == S_MUL;
   assign cmd.start    = state_ff == S_START;
   assign cmd.load_out = (state_ff == S_OUT) && status.out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b1;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               // zero-depth pixels only advance the raster position
               if (req_valid && ready_ff && !status.missing) begin
                  state_ff <= S_MUL;
                  ready_ff <= 1'b0;
               end
            end
            S_MUL:   state_ff <= S_START;
            S_START: state_ff <= S_WAIT;
            S_WAIT: begin
               if (!status.busy) begin
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (status.out_free) begin
                  state_ff <= S_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= S_IDLE;
               ready_ff <= 1'b1;
            end
         endcase
      end
   end

endmodule

/* sv/dcpc_datapath.sv */
// ---------------------------------------------------------------------------
// dcpc_datapath
// Raster counters, numerator magnitudes, the two products, two dividers,
// sign/saturation and the output register.
// ---------------------------------------------------------------------------
module dcpc_datapath import dcpc_pkg::*; #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic [DEPTH_W-1:0] req_depth_value,
   input  logic [COLOR_W-1:0] req_blue_in,
   input  logic [COLOR_W-1:0] req_green_in,
   input  logic [COLOR_W-1:0] req_red_in,
   dcpc_rsp_if.source         rsp_if
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int XL_W  = $clog2(MAX_WIDTH + 1);
   localparam int YL_W  = $clog2(MAX_HEIGHT + 1);
   localparam int XS_W  = (XL_W > SIZE_W) ? XL_W : SIZE_W;
   localparam int YS_W  = (YL_W > SIZE_W) ? YL_W : SIZE_W;
   localparam logic [XS_W-1:0] W_MAX = XS_W'(MAX_WIDTH);
   localparam logic [YS_W-1:0] H_MAX = YS_W'(MAX_HEIGHT);

   // sign and saturate a quotient magnitude into a 48-bit pattern
   function automatic logic [POINT_W-1:0] apply_sign(input logic neg, input logic ovf,
                                                     input logic [POINT_W-1:0] mag);
      logic big;
      big = ovf || (neg ? (mag > NEG_LIMIT) : (mag > POS_LIMIT));
      if (neg) begin
         return big ? NEG_LIMIT : (POINT_W'(0) - mag);
      end
      return big ? POS_LIMIT : mag;
   endfunction

   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [XS_W-1:0]    w_cfg, w_eff, col_plus;
   logic [YS_W-1:0]    h_cfg, h_eff, row_plus;

   logic [CFG_W-1:0]   pos_x, pos_y, mag_x, mag_y;
   logic               neg_x, neg_y;

   logic [CFG_W-1:0]   mag_x_ff, mag_y_ff;
   logic               neg_x_ff, neg_y_ff;
   logic [DEPTH_W-1:0] depth_ff;
   logic [COLOR_W-1:0] blue_ff, green_ff, red_ff;
   logic [PROD_W-1:0]  prod_x_ff, prod_y_ff;

   logic               busy_x, busy_y, ovf_x, ovf_y;
   logic [QUO_W-1:0]   quo_x, quo_y;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [POINT_W-1:0] point_x_ff, point_y_ff;
   logic [DEPTH_W-1:0] point_z_ff;
   logic [COLOR_W-1:0] blue_out_ff, green_out_ff, red_out_ff;

   // effective geometry: zero reads as one, clamp to the maximum
   always_comb begin
      w_cfg = XS_W'(cfg.image_width);
      h_cfg = YS_W'(cfg.image_height);
      priority if (w_cfg == '0) w_eff = XS_W'(1);
      else if (w_cfg > W_MAX)   w_eff = W_MAX;
      else                      w_eff = w_cfg;
      priority if (h_cfg == '0) h_eff = YS_W'(1);
      else if (h_cfg > H_MAX)   h_eff = H_MAX;
      else                      h_eff = h_cfg;
   end

   // raster counters
   assign col_plus = XS_W'(col_ff) + XS_W'(1);
   assign row_plus = YS_W'(row_ff) + YS_W'(1);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (cmd.accept) begin
         if (col_plus >= w_eff) begin
            col_in = '0;
            row_in = (row_plus >= h_eff) ? '0 : row_plus[ROW_W-1:0];
         end else begin
            col_in = col_plus[COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // numerator magnitude |pos - center| in Q16.16 and its sign
   assign pos_x = CFG_W'({col_ff, {Q_FRAC{1'b0}}});
   assign pos_y = CFG_W'({row_ff, {Q_FRAC{1'b0}}});
   assign neg_x = pos_x < cfg.center_x;
   assign neg_y = pos_y < cfg.center_y;
   assign mag_x = neg_x ? (cfg.center_x - pos_x) : (pos_x - cfg.center_x);
   assign mag_y = neg_y ? (cfg.center_y - pos_y) : (pos_y - cfg.center_y);

   // pixel capture and products
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mag_x_ff <= mag_x;
         mag_y_ff <= mag_y;
         neg_x_ff <= neg_x;
         neg_y_ff <= neg_y;
         depth_ff <= req_depth_value;
         blue_ff  <= req_blue_in;
         green_ff <= req_green_in;
         red_ff   <= req_red_in;
      end
      if (cmd.mul) begin
         prod_x_ff <= PROD_W'(mag_x_ff) * PROD_W'(depth_ff);
         prod_y_ff <= PROD_W'(mag_y_ff) * PROD_W'(depth_ff);
      end
   end

   // dividers, one per axis
   dcpc_div u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.start),
      .dividend (prod_x_ff),
      .divisor  (cfg.focal_x),
      .busy     (busy_x),
      .ovf      (ovf_x),
      .quotient (quo_x)
   );

   dcpc_div u_div_y (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.start),
      .dividend (prod_y_ff),
      .divisor  (cfg.focal_y),
      .busy     (busy_y),
      .ovf      (ovf_y),
      .quotient (quo_y)
   );

   // output register
   assign rsp_valid_in = cmd.load_out ? 1'b1 : (rsp_if.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         point_x_ff   <= apply_sign(neg_x_ff, ovf_x, quo_x);
         point_y_ff   <= apply_sign(neg_y_ff, ovf_y, quo_y);
         point_z_ff   <= depth_ff;
         blue_out_ff  <= blue_ff;
         green_out_ff <= green_ff;
         red_out_ff   <= red_ff;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.point_x   = $signed(point_x_ff);
   assign rsp_if.point_y   = $signed(point_y_ff);
   assign rsp_if.point_z   = point_z_ff;
   assign rsp_if.blue_out  = blue_out_ff;
   assign rsp_if.green_out = green_out_ff;
   assign rsp_if.red_out   = red_out_ff;

   assign status.missing  = req_depth_value == '0;
   assign status.busy     = busy_x || busy_y;
   assign status.out_free = !rsp_valid_ff || rsp_if.ready;

   // checks
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_if.ready))
      else $error("pending point overwritten");

   a_accept_div_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |-> !(busy_x || busy_y))
      else $error("pixel accepted while dividing");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      32'(col_ff) < 32'(MAX_WIDTH))
      else $error("column counter out of range");

   a_pos_sign: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_out && !neg_x_ff) |=> !rsp_if.point_x[POINT_W-1])
      else $error("non-negative x numerator gave negative point");

   a_z_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> (rsp_if.point_z != '0))
      else $error("point emitted for missing depth");

endmodule

/* sv/depth_to_color_point_cloud_unit.sv */
// ---------------------------------------------------------------------------
// depth_to_color_point_cloud_unit
// Back-projects a raster stream of depth/color pixels into colored 3-D
// points through a pinhole camera model.
//
//   channel  | dir | handshake          | beat
//   ---------+-----+--------------------+--------------------------------------
//   req_if   | in  | valid/ready        | depth_value, blue_in, green_in, red_in
//   rsp_if   | out | valid/ready        | point_x/y/z, blue/green/red_out
//   apb      | in  | psel/penable/pready| 6 regs at 4*i: fx, fy, cx, cy, w, h
//
// A pixel with nonzero depth holds the input through capture, multiply,
// divider launch, the quotient-bit iterations, a step to see the dividers
// done and hand-off. The quotient-bit iterations of the two radix-2
// dividers (x and y side by side) take most of a pixel's time. A zero
// product or a quotient past 48 bits skips the iterations. A zero-depth
// pixel is taken from the idle state and produces no beat.
// Reset is synchronous; it restores register defaults and zeroes the
// raster counters. A stalled rsp_if holds only the hand-off step: the next
// pixel is taken while a finished point waits in the output register.
// ---------------------------------------------------------------------------
module depth_to_color_point_cloud_unit import dcpc_pkg::*; #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   dcpc_req_if.sink              req_if,
   dcpc_rsp_if.source            rsp_if,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;
   logic       req_ready;

   assign req_if.ready = req_ready;

   // register file
   dcpc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // sequencer
   dcpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic and output register
   dcpc_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .cmd             (cmd),
      .status          (status),
      .req_depth_value (req_if.depth_value),
      .req_blue_in     (req_if.blue_in),
      .req_green_in    (req_if.green_in),
      .req_red_in      (req_if.red_in),
      .rsp_if          (rsp_if)
   );

endmodule
